/* hdl/clnib_pkg.sv */
`timescale 1ns / 1ps

package clnib_pkg;

  // Widths of the configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 25;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PAUSE_TICKS      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_POWERUP_WAIT     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WAIT_FIRST       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WAIT_SECOND      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_WAIT_NIBBLE_MODE = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_FUNCTION_BYTE    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_BYTE       = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_DISPLAY_BYTE     = 3'd7;

  // Register reset values
  localparam logic [15:0] PAUSE_TICKS_RST      = 16'd1000;
  localparam logic [19:0] PAUSE_LONG_RST       = 20'd10000;
  localparam logic [24:0] POWERUP_WAIT_RST     = 25'd17500000;
  localparam logic [24:0] WAIT_FIRST_RST       = 25'd1700000;
  localparam logic [24:0] WAIT_SECOND_RST      = 25'd300000;
  localparam logic [24:0] WAIT_NIBBLE_MODE_RST = 25'd1500000;
  localparam logic [7:0]  FUNCTION_BYTE_RST    = 8'h28;
  localparam logic [7:0]  ENTRY_BYTE_RST       = 8'h06;
  localparam logic [7:0]  DISPLAY_BYTE_RST     = 8'h0C;

  // Display instructions and init nibbles
  localparam logic [7:0] INSTR_LINE2_ADDR  = 8'hC0;
  localparam logic [7:0] INSTR_RETURN_HOME = 8'h02;
  localparam logic [7:0] INSTR_DISPLAY_OFF = 8'h08;
  localparam logic [7:0] INSTR_CLEAR       = 8'h01;
  localparam logic [3:0] NIB_WAKE          = 4'b0011;
  localparam logic [3:0] NIB_FOUR_BIT      = 4'b0010;

  // Cursor positions
  localparam logic [4:0] POS_LINE2   = 5'd8;
  localparam logic [4:0] POS_LAST    = 5'd15;

  // Init step numbers
  localparam logic [3:0] STEP_NIBBLE_LAST = 4'd3;
  localparam logic [3:0] STEP_BYTES_FIRST = 4'd4;
  localparam logic [3:0] STEP_OFF         = 4'd5;
  localparam logic [3:0] STEP_CLEAR       = 4'd6;
  localparam logic [3:0] STEP_ENTRY       = 4'd7;
  localparam logic [3:0] STEP_BYTES_END   = 4'd8;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_PRINT = 2'd1,
    CMD_BYTE  = 2'd2,
    CMD_INIT  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t       op;
    logic [7:0] value;
    logic       busy_line;
  } item_t;

  typedef struct packed {
    logic       pin_e;
    logic       pin_rs;
    logic       pin_rw;
    logic [3:0] data_nibble;
    logic       data_drive;
    logic       ready_res;
    logic       accepted;
  } result_t;

endpackage

/* hdl/clnib_fifo.sv */
`timescale 1ns / 1ps

module clnib_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  T     wdata,
  output logic full,
  input  logic pop,
  output T     rdata,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T              mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Store the incoming entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/clnib_seq.sv */
`timescale 1ns / 1ps

module clnib_seq
  import clnib_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   item_valid,
  input  item_t                  item,
  output logic                   item_take,
  output logic                   res_push,
  output result_t                res,
  input  logic                   res_full
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_POLL_E1,
    PH_POLL_L1,
    PH_POLL_E2,
    PH_POLL_L2,
    PH_NIB_E,
    PH_NIB_L,
    PH_INIT_WAIT,
    PH_INIT_E
  } phase_t;

  // Configuration registers
  logic [15:0] pause_ticks;
  logic [19:0] pause_long;
  logic [24:0] powerup_wait;
  logic [24:0] wait_first;
  logic [24:0] wait_second;
  logic [24:0] wait_nibble_mode;
  logic [7:0]  function_byte;
  logic [7:0]  entry_byte;
  logic [7:0]  display_byte;

  // Sequencer state
  phase_t      phase, phase_next;
  logic [24:0] tick_count, tick_count_next;
  logic [3:0]  init_step, init_step_next;
  logic [8:0]  pending_prefix, pending_prefix_next;
  logic [8:0]  pending_byte, pending_byte_next;
  logic [4:0]  line_position, line_position_next;
  logic        current_nibble_low, current_nibble_low_next;

  logic go;

  assign go        = item_valid && !res_full;
  assign item_take = go;
  assign res_push  = go;

  // Hold configuration; keep the ten-pause length ready alongside pause_ticks
  always_ff @(posedge clk) begin
    if (rst) begin
      pause_ticks      <= PAUSE_TICKS_RST;
      pause_long       <= PAUSE_LONG_RST;
      powerup_wait     <= POWERUP_WAIT_RST;
      wait_first       <= WAIT_FIRST_RST;
      wait_second      <= WAIT_SECOND_RST;
      wait_nibble_mode <= WAIT_NIBBLE_MODE_RST;
      function_byte    <= FUNCTION_BYTE_RST;
      entry_byte       <= ENTRY_BYTE_RST;
      display_byte     <= DISPLAY_BYTE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PAUSE_TICKS: begin
          pause_ticks <= cfg_data[15:0];
          pause_long  <= {1'b0, cfg_data[15:0], 3'b000} + {3'b000, cfg_data[15:0], 1'b0};
        end
        REG_POWERUP_WAIT:     powerup_wait     <= cfg_data;
        REG_WAIT_FIRST:       wait_first       <= cfg_data;
        REG_WAIT_SECOND:      wait_second      <= cfg_data;
        REG_WAIT_NIBBLE_MODE: wait_nibble_mode <= cfg_data;
        REG_FUNCTION_BYTE:    function_byte    <= cfg_data[7:0];
        REG_ENTRY_BYTE:       entry_byte       <= cfg_data[7:0];
        REG_DISPLAY_BYTE:     display_byte     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Work out pins and the next state for one tick
  always_comb begin : tick_logic
    logic        ready;
    logic        acc;
    logic [8:0]  cur;
    logic [24:0] tc_inc;
    logic [24:0] len;
    logic [7:0]  ib;

    phase_next              = phase;
    tick_count_next         = tick_count;
    init_step_next          = init_step;
    pending_prefix_next     = pending_prefix;
    pending_byte_next       = pending_byte;
    line_position_next      = line_position;
    current_nibble_low_next = current_nibble_low;

    ready = (phase == PH_IDLE);
    acc   = ready && (item.op != CMD_TICK);

    // Take a new command when idle
    if (acc) begin
      unique case (item.op)
        CMD_PRINT: begin
          pending_prefix_next = '0;
          if (line_position == POS_LINE2) begin
            pending_prefix_next = {1'b1, INSTR_LINE2_ADDR};
            line_position_next  = line_position + 1'b1;
          end else if (line_position > POS_LAST) begin
            pending_prefix_next = {1'b1, INSTR_RETURN_HOME};
            line_position_next  = 5'd1;
          end else begin
            line_position_next  = line_position + 1'b1;
          end
          pending_byte_next       = {1'b1, item.value};
          phase_next              = PH_POLL_E1;
          tick_count_next         = '0;
          current_nibble_low_next = 1'b0;
        end
        CMD_BYTE: begin
          pending_prefix_next     = '0;
          pending_byte_next       = {1'b0, item.value};
          phase_next              = PH_POLL_E1;
          tick_count_next         = '0;
          current_nibble_low_next = 1'b0;
        end
        CMD_INIT: begin
          init_step_next      = '0;
          pending_prefix_next = '0;
          phase_next          = PH_INIT_WAIT;
          tick_count_next     = '0;
        end
        default: ;
      endcase
    end

    // Drive pins from the state after any command
    cur = pending_prefix_next[8] ? {1'b0, pending_prefix_next[7:0]} : pending_byte_next;
    res             = '0;
    res.data_drive  = 1'b1;
    res.ready_res   = ready;
    res.accepted    = acc;
    unique case (phase_next)
      PH_POLL_E1, PH_POLL_E2: begin
        res.pin_e      = 1'b1;
        res.pin_rw     = 1'b1;
        res.data_drive = 1'b0;
      end
      PH_POLL_L1, PH_POLL_L2: begin
        res.pin_rw     = 1'b1;
        res.data_drive = 1'b0;
      end
      PH_NIB_E, PH_NIB_L: begin
        res.pin_e       = (phase_next == PH_NIB_E);
        res.pin_rs      = cur[8];
        res.data_nibble = current_nibble_low_next ? cur[3:0] : cur[7:4];
      end
      PH_INIT_WAIT: begin
        if (init_step_next == '0) begin
          res.data_nibble = '0;
        end else if (init_step_next >= STEP_BYTES_FIRST) begin
          res.data_nibble = NIB_FOUR_BIT;
        end else begin
          res.data_nibble = NIB_WAKE;
        end
      end
      PH_INIT_E: begin
        res.pin_e       = 1'b1;
        res.data_nibble = (init_step_next == STEP_NIBBLE_LAST) ? NIB_FOUR_BIT : NIB_WAKE;
      end
      default: ;
    endcase

    // Length of the current phase
    unique case (phase_next)
      PH_NIB_L: len = current_nibble_low_next ? {5'd0, pause_long} : {9'd0, pause_ticks};
      PH_INIT_WAIT: begin
        priority case (init_step_next)
          4'd0:    len = powerup_wait;
          4'd1:    len = wait_first;
          4'd2:    len = wait_second;
          default: len = wait_nibble_mode;
        endcase
      end
      default: len = {9'd0, pause_ticks};
    endcase

    // Next init byte after the current step
    priority case (init_step_next + 1'b1)
      STEP_BYTES_FIRST: ib = function_byte;
      STEP_OFF:         ib = INSTR_DISPLAY_OFF;
      STEP_CLEAR:       ib = INSTR_CLEAR;
      STEP_ENTRY:       ib = entry_byte;
      default:          ib = display_byte;
    endcase

    // Count the tick and advance the phase at its end
    tc_inc = tick_count_next + 1'b1;
    if (phase_next != PH_IDLE) begin
      if (tc_inc >= len) begin
        tick_count_next = '0;
        unique case (phase_next)
          PH_POLL_E1: phase_next = item.busy_line ? PH_POLL_L1 : PH_NIB_E;
          PH_POLL_L1: phase_next = PH_POLL_E2;
          PH_POLL_E2: phase_next = PH_POLL_L2;
          PH_POLL_L2: phase_next = PH_POLL_E1;
          PH_NIB_E:   phase_next = PH_NIB_L;
          PH_NIB_L: begin
            if (!current_nibble_low_next) begin
              current_nibble_low_next = 1'b1;
              phase_next              = PH_NIB_E;
            end else begin
              current_nibble_low_next = 1'b0;
              if (pending_prefix_next[8]) begin
                pending_prefix_next = '0;
                phase_next          = PH_POLL_E1;
              end else if (init_step_next >= STEP_BYTES_FIRST &&
                           init_step_next < STEP_BYTES_END) begin
                init_step_next    = init_step_next + 1'b1;
                pending_byte_next = {1'b0, ib};
                phase_next        = PH_POLL_E1;
              end else begin
                init_step_next = '0;
                phase_next     = PH_IDLE;
              end
            end
          end
          PH_INIT_WAIT: begin
            if (init_step_next < STEP_BYTES_FIRST) begin
              phase_next = PH_INIT_E;
            end else begin
              init_step_next          = STEP_BYTES_FIRST;
              pending_prefix_next     = '0;
              pending_byte_next       = {1'b0, function_byte};
              phase_next              = PH_POLL_E1;
              current_nibble_low_next = 1'b0;
            end
          end
          PH_INIT_E: begin
            init_step_next = init_step_next + 1'b1;
            phase_next     = PH_INIT_WAIT;
          end
          default: phase_next = PH_IDLE;
        endcase
      end else begin
        tick_count_next = tc_inc;
      end
    end
  end

  // Hold sequencer state; advance on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_IDLE;
      tick_count         <= '0;
      init_step          <= '0;
      pending_prefix     <= '0;
      pending_byte       <= '0;
      line_position      <= '0;
      current_nibble_low <= 1'b0;
    end else if (go) begin
      phase              <= phase_next;
      tick_count         <= tick_count_next;
      init_step          <= init_step_next;
      pending_prefix     <= pending_prefix_next;
      pending_byte       <= pending_byte_next;
      line_position      <= line_position_next;
      current_nibble_low <= current_nibble_low_next;
    end
  end

endmodule

/* hdl/char_lcd_nibble_interface.sv */
`timescale 1ns / 1ps
// Character LCD sequencer for a 4-bit bus, advanced one tick per input item.
// Input channel: push with cmd, value and busy_line while full is low; each
// transfer is one tick (cmd tick, print, command byte or init).
// Result channel: empty low shows one pin snapshot (pin_e, pin_rs, pin_rw,
// data_nibble, data_drive, ready_res, accepted); pop takes it.
// Every input item yields exactly one result, in order.
// Path: an input item waits in the command queue; the sequencer's result is
// registered into the result queue and shown on the result ports from there.
// Throughput: one item per cycle while results are popped; the sequencer
// settles each tick combinationally, and two small queues (command side,
// result side) decouple it from the ports.
// Stalls: when pop is held low the result queue fills, the sequencer stops,
// then the command queue fills and full rises; nothing is lost.
// Reset (rst, synchronous): queues empty, sequencer idle, cursor at zero,
// configuration registers back to their defaults.
// Configuration: cfg_write with cfg_index and cfg_data, taken at once; write
// only while no result is outstanding.
module char_lcd_nibble_interface
  import clnib_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [1:0]             cmd,
  input  logic [7:0]             value,
  input  logic                   busy_line,
  output logic                   empty,
  input  logic                   pop,
  output logic                   pin_e,
  output logic                   pin_rs,
  output logic                   pin_rw,
  output logic [3:0]             data_nibble,
  output logic                   data_drive,
  output logic                   ready_res,
  output logic                   accepted,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  item_t   in_item;
  item_t   q_item;
  logic    q_empty;
  logic    q_take;
  result_t seq_res;
  logic    seq_push;
  logic    res_full;
  result_t out_res;

  // Classify the incoming command
  always_comb begin
    in_item.op        = cmd_t'(cmd);
    in_item.value     = value;
    in_item.busy_line = busy_line;
  end

  clnib_fifo #(
    .T     (item_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (in_item),
    .full  (full),
    .pop   (q_take),
    .rdata (q_item),
    .empty (q_empty)
  );

  clnib_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (!q_empty),
    .item       (q_item),
    .item_take  (q_take),
    .res_push   (seq_push),
    .res        (seq_res),
    .res_full   (res_full)
  );

  clnib_fifo #(
    .T     (result_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (seq_push),
    .wdata (seq_res),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_res),
    .empty (empty)
  );

  // Unpack the oldest result onto the ports
  assign pin_e       = out_res.pin_e;
  assign pin_rs      = out_res.pin_rs;
  assign pin_rw      = out_res.pin_rw;
  assign data_nibble = out_res.data_nibble;
  assign data_drive  = out_res.data_drive;
  assign ready_res   = out_res.ready_res;
  assign accepted    = out_res.accepted;

endmodule
